[rtl/necirtx_pkg.sv]
// Package for the NEC infrared frame transmitter.
// Holds the word types, register indexes, reset values and phase codes.
// No dependencies.
`default_nettype none

package necirtx_pkg;

    localparam int unsigned DUR_W    = 20;
    localparam int unsigned CARR_W   = 16;
    localparam int unsigned CFG_IX_W = 3;
    localparam int unsigned CFG_D_W  = 20;
    localparam int unsigned BITS_N   = 32;
    localparam int unsigned BIT_IX_W = 5;

    typedef enum logic [CFG_IX_W-1:0] {
        REG_HEADER_MARK  = 3'd0,
        REG_HEADER_SPACE = 3'd1,
        REG_BIT_MARK     = 3'd2,
        REG_ONE_SPACE    = 3'd3,
        REG_ZERO_SPACE   = 3'd4,
        REG_CARR_PERIOD  = 3'd5,
        REG_CARR_DUTY    = 3'd6
    } cfg_index_t;

    localparam logic [DUR_W-1:0]  RST_HEADER_MARK  = 20'd9000;
    localparam logic [DUR_W-1:0]  RST_HEADER_SPACE = 20'd4500;
    localparam logic [DUR_W-1:0]  RST_BIT_MARK     = 20'd562;
    localparam logic [DUR_W-1:0]  RST_ONE_SPACE    = 20'd1687;
    localparam logic [DUR_W-1:0]  RST_ZERO_SPACE   = 20'd562;
    localparam logic [CARR_W-1:0] RST_CARR_PERIOD  = 16'd26;
    localparam logic [CARR_W-1:0] RST_CARR_DUTY    = 16'd9;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_HDR_MARK  = 6'b000010,
        PH_HDR_SPACE = 6'b000100,
        PH_BIT_MARK  = 6'b001000,
        PH_BIT_SPACE = 6'b010000,
        PH_STOP_MARK = 6'b100000
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] frame_address;
        logic [7:0] frame_command;
    } in_word_t;

    typedef struct packed {
        logic ir_out;
        logic envelope;
        logic busy_res;
        logic frame_done;
        logic accepted;
    } out_word_t;

endpackage

`default_nettype wire

[rtl/nec_ir_frame_transmitter_unit.sv]
// NEC infrared frame transmitter, top level.
// An accepted word's result word is registered and shown in the cycle after it is taken.
// Throughput: one word per cycle unless a held result stalls in_ready; the phase timer,
// bit mux and carrier counter update in a single registered pass.
// Reset (rst_n low, asynchronous): idle phase, counters cleared, registers
// at their default timings, result register empty.
// Depends on necirtx_pkg.
`default_nettype none

module nec_ir_frame_transmitter_unit (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire  [necirtx_pkg::CFG_IX_W-1:0]     cfg_index,
    input  wire  [necirtx_pkg::CFG_D_W-1:0]      cfg_data,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  necirtx_pkg::in_word_t                in_data,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output necirtx_pkg::out_word_t               out_data
);
    import necirtx_pkg::*;

    logic [DUR_W-1:0]    hdr_mark_reg, hdr_space_reg, bit_mark_reg;
    logic [DUR_W-1:0]    one_space_reg, zero_space_reg;
    logic [CARR_W-1:0]   carr_period_reg, carr_duty_reg;

    phase_t              phase_reg, phase_next;
    logic [DUR_W-1:0]    interval_reg, interval_next;
    logic [BIT_IX_W-1:0] bit_ix_reg, bit_ix_next;
    logic [BITS_N-1:0]   frame_bits_reg, frame_bits_next;
    logic [CARR_W-1:0]   carr_cnt_reg, carr_cnt_next;

    out_word_t           out_data_reg, out_data_next;
    logic                out_valid_reg;

    logic                in_fire;
    logic [DUR_W-1:0]    raw_len, phase_len;
    logic [DUR_W:0]      count_inc;
    logic                done, acc, env;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_mark_reg    <= RST_HEADER_MARK;
            hdr_space_reg   <= RST_HEADER_SPACE;
            bit_mark_reg    <= RST_BIT_MARK;
            one_space_reg   <= RST_ONE_SPACE;
            zero_space_reg  <= RST_ZERO_SPACE;
            carr_period_reg <= RST_CARR_PERIOD;
            carr_duty_reg   <= RST_CARR_DUTY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEADER_MARK:  hdr_mark_reg    <= cfg_data;
                REG_HEADER_SPACE: hdr_space_reg   <= cfg_data;
                REG_BIT_MARK:     bit_mark_reg    <= cfg_data;
                REG_ONE_SPACE:    one_space_reg   <= cfg_data;
                REG_ZERO_SPACE:   zero_space_reg  <= cfg_data;
                REG_CARR_PERIOD:  carr_period_reg <= cfg_data[CARR_W-1:0];
                REG_CARR_DUTY:    carr_duty_reg   <= cfg_data[CARR_W-1:0];
                default:          ;
            endcase
        end
    end

    // duration of the current phase, never below one tick
    always_comb
    begin
        unique case (phase_reg)
            PH_HDR_MARK:  raw_len = hdr_mark_reg;
            PH_HDR_SPACE: raw_len = hdr_space_reg;
            PH_BIT_MARK:  raw_len = bit_mark_reg;
            PH_BIT_SPACE: raw_len = frame_bits_reg[bit_ix_reg] ? one_space_reg
                                                                : zero_space_reg;
            PH_STOP_MARK: raw_len = bit_mark_reg;
            default:      raw_len = {{(DUR_W-1){1'b0}}, 1'b1};
        endcase
        phase_len = (raw_len == '0) ? {{(DUR_W-1){1'b0}}, 1'b1} : raw_len;
    end

    assign count_inc = {1'b0, interval_reg} + {{DUR_W{1'b0}}, 1'b1};

    always_comb
    begin
        phase_next      = phase_reg;
        interval_next   = interval_reg;
        bit_ix_next     = bit_ix_reg;
        frame_bits_next = frame_bits_reg;
        carr_cnt_next   = carr_cnt_reg;
        done            = 1'b0;
        acc             = 1'b0;

        if (in_data.kind == KIND_START)
        begin
            if (phase_reg == PH_IDLE)
            begin
                frame_bits_next = {~in_data.frame_command, in_data.frame_command,
                                   ~in_data.frame_address, in_data.frame_address};
                bit_ix_next     = '0;
                interval_next   = '0;
                phase_next      = PH_HDR_MARK;
                acc             = 1'b1;
            end
        end
        else
        begin
            if (carr_cnt_reg >= carr_period_reg)
                carr_cnt_next = '0;
            else
                carr_cnt_next = carr_cnt_reg + {{(CARR_W-1){1'b0}}, 1'b1};

            if (phase_reg != PH_IDLE)
            begin
                if (count_inc >= {1'b0, phase_len})
                begin
                    interval_next = '0;
                    unique case (phase_reg)
                        PH_HDR_MARK:  phase_next = PH_HDR_SPACE;
                        PH_HDR_SPACE: phase_next = PH_BIT_MARK;
                        PH_BIT_MARK:  phase_next = PH_BIT_SPACE;
                        PH_BIT_SPACE:
                        begin
                            if (bit_ix_reg == BIT_IX_W'(BITS_N - 1))
                                phase_next = PH_STOP_MARK;
                            else
                            begin
                                bit_ix_next = bit_ix_reg + {{(BIT_IX_W-1){1'b0}}, 1'b1};
                                phase_next  = PH_BIT_MARK;
                            end
                        end
                        PH_STOP_MARK:
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        default:      phase_next = PH_IDLE;
                    endcase
                end
                else
                    interval_next = count_inc[DUR_W-1:0];
            end
        end

        env = (phase_next == PH_HDR_MARK) || (phase_next == PH_BIT_MARK)
              || (phase_next == PH_STOP_MARK);
        out_data_next.ir_out     = env && (carr_cnt_next < carr_duty_reg);
        out_data_next.envelope   = env;
        out_data_next.busy_res   = (phase_next != PH_IDLE);
        out_data_next.frame_done = done;
        out_data_next.accepted   = acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            interval_reg   <= '0;
            bit_ix_reg     <= '0;
            frame_bits_reg <= '0;
            carr_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            interval_reg   <= interval_next;
            bit_ix_reg     <= bit_ix_next;
            frame_bits_reg <= frame_bits_next;
            carr_cnt_reg   <= carr_cnt_next;
            out_valid_reg  <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            out_data_reg <= out_data_next;
    end

    a_done_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.frame_done |-> !out_data.busy_res && !out_data.envelope)
        else $error("frame_done with frame still running");

    a_ir_needs_env: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.ir_out |-> out_data.envelope)
        else $error("ir_out high outside a mark");

    a_busy_start_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (in_data.kind == KIND_START) && (phase_reg != PH_IDLE)
        |=> out_valid && !out_data.accepted && $stable(phase_reg))
        else $error("start while busy was latched");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (phase_reg == PH_IDLE) && (in_data.kind == KIND_TICK)
        |=> !out_data.busy_res && !out_data.frame_done)
        else $error("tick while idle left idle state");

endmodule

`default_nettype wire

[sim/tb_nec_ir_frame_transmitter_unit.sv]
`timescale 1ns / 1ps
// Testbench for nec_ir_frame_transmitter_unit: directed and random start/tick words, each
// result word checked against a cycle-level model of the transmitter held in this file.
// Depends on necirtx_pkg and the transmitter RTL.

module tb_nec_ir_frame_transmitter_unit;
    import necirtx_pkg::*;

    localparam logic [CFG_IX_W-1:0] REG_SPARE = 3'd7;
    localparam logic [CFG_D_W-1:0]  DUR_MAX   = 20'hFFFFF;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CFG_IX_W-1:0] cfg_index = '0;
    logic [CFG_D_W-1:0]  cfg_data  = '0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    in_word_t            in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_word_t           out_data;

    logic [DUR_W-1:0]  set_header_mark  = RST_HEADER_MARK;
    logic [DUR_W-1:0]  set_header_space = RST_HEADER_SPACE;
    logic [DUR_W-1:0]  set_bit_mark     = RST_BIT_MARK;
    logic [DUR_W-1:0]  set_one_space    = RST_ONE_SPACE;
    logic [DUR_W-1:0]  set_zero_space   = RST_ZERO_SPACE;
    logic [CARR_W-1:0] set_period       = RST_CARR_PERIOD;
    logic [CARR_W-1:0] set_duty         = RST_CARR_DUTY;

    phase_t              tx_phase   = PH_IDLE;
    logic [DUR_W-1:0]    tx_count   = '0;
    logic [BIT_IX_W-1:0] tx_bit_ix  = '0;
    logic [BITS_N-1:0]   tx_bits    = '0;
    logic [CARR_W-1:0]   carr_count = '0;

    in_word_t    pending_words[$];
    out_word_t   expected_status[$];
    int unsigned error_count    = 0;
    int unsigned send_gap       = 0;
    int unsigned send_calm      = 0;
    int unsigned take_stall     = 0;
    int unsigned take_calm      = 0;
    logic        long_hold_done = 1'b0;

    nec_ir_frame_transmitter_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    function automatic logic [DUR_W-1:0] ticks_of(input logic [DUR_W-1:0] d);
        return (d == '0) ? DUR_W'(1) : d;
    endfunction

    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic in_word_t make_word(input logic kind);
        in_word_t w;
        w.kind          = kind;
        w.frame_address = 8'($urandom_range(0, 255));
        w.frame_command = 8'($urandom_range(0, 255));
        return w;
    endfunction

    task automatic step_ir_frame(input in_word_t w, output out_word_t r);
        logic [DUR_W:0]   next_count;
        logic [DUR_W-1:0] span;
        logic             done;
        logic             took;
        logic             env;
        done = 1'b0;
        took = 1'b0;
        if (w.kind == KIND_START)
        begin
            if (tx_phase == PH_IDLE)
            begin
                tx_bits   = {~w.frame_command, w.frame_command,
                             ~w.frame_address, w.frame_address};
                tx_bit_ix = '0;
                tx_count  = '0;
                tx_phase  = PH_HDR_MARK;
                took      = 1'b1;
            end
        end
        else
        begin
            carr_count = (carr_count >= set_period) ? '0 : carr_count + CARR_W'(1);
            if (tx_phase != PH_IDLE)
            begin
                case (tx_phase)
                    PH_HDR_MARK:  span = ticks_of(set_header_mark);
                    PH_HDR_SPACE: span = ticks_of(set_header_space);
                    PH_BIT_SPACE: span = ticks_of(tx_bits[tx_bit_ix] ? set_one_space
                                                                     : set_zero_space);
                    default:      span = ticks_of(set_bit_mark);
                endcase
                next_count = {1'b0, tx_count} + {{DUR_W{1'b0}}, 1'b1};
                if (next_count >= {1'b0, span})
                begin
                    tx_count = '0;
                    case (tx_phase)
                        PH_HDR_MARK:  tx_phase = PH_HDR_SPACE;
                        PH_HDR_SPACE: tx_phase = PH_BIT_MARK;
                        PH_BIT_MARK:  tx_phase = PH_BIT_SPACE;
                        PH_BIT_SPACE:
                        begin
                            if (tx_bit_ix == BIT_IX_W'(BITS_N - 1))
                                tx_phase = PH_STOP_MARK;
                            else
                            begin
                                tx_bit_ix = tx_bit_ix + BIT_IX_W'(1);
                                tx_phase  = PH_BIT_MARK;
                            end
                        end
                        default:
                        begin
                            tx_phase = PH_IDLE;
                            done     = 1'b1;
                        end
                    endcase
                end
                else
                    tx_count = next_count[DUR_W-1:0];
            end
        end
        env = (tx_phase == PH_HDR_MARK) || (tx_phase == PH_BIT_MARK)
              || (tx_phase == PH_STOP_MARK);
        r.ir_out     = env && (carr_count < set_duty);
        r.envelope   = env;
        r.busy_res   = (tx_phase != PH_IDLE);
        r.frame_done = done;
        r.accepted   = took;
    endtask

    task automatic check_field(input string field, input logic want, input logic got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t %s: expected %0b, got %0b", $time, field, want, got);
        end
    endtask

    // Sender: offer the next word once the current one is taken and its gap has run out
    always @(posedge clk)
    begin : drive
        out_word_t predicted;
        logic      offer;
        offer = in_valid;
        if (in_valid && in_ready)
        begin
            step_ir_frame(in_data, predicted);
            expected_status.push_back(predicted);
            offer = 1'b0;
        end
        if (!offer)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (pending_words.size() > 0)
            begin
                in_data  <= pending_words.pop_front();
                offer     = 1'b1;
                send_gap  = pick_gap(send_calm);
            end
        end
        in_valid <= offer;
    end

    // Receiver: check each word taken, then decide the ready for the next edge
    always @(posedge clk)
    begin : receive
        out_word_t want;
        if (out_valid && out_ready)
        begin
            if (expected_status.size() == 0)
            begin
                error_count++;
                $display("%0t unexpected word: expected none, got %b", $time, out_data);
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("ir_out", want.ir_out, out_data.ir_out);
                check_field("envelope", want.envelope, out_data.envelope);
                check_field("busy_res", want.busy_res, out_data.busy_res);
                check_field("frame_done", want.frame_done, out_data.frame_done);
                check_field("accepted", want.accepted, out_data.accepted);
            end
        end
        if (!long_hold_done && pending_words.size() > 100)
        begin
            take_stall     = 400;
            long_hold_done = 1'b1;
        end
        if (take_stall > 0)
        begin
            take_stall--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 99) < 20)
                take_stall = pick_gap(take_calm);
        end
    end

    task automatic write_reg(input logic [CFG_IX_W-1:0] ix, input logic [CFG_D_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= ix;
        cfg_data  <= data;
        case (ix)
            REG_HEADER_MARK:  set_header_mark  = data;
            REG_HEADER_SPACE: set_header_space = data;
            REG_BIT_MARK:     set_bit_mark     = data;
            REG_ONE_SPACE:    set_one_space    = data;
            REG_ZERO_SPACE:   set_zero_space   = data;
            REG_CARR_PERIOD:  set_period       = data[CARR_W-1:0];
            REG_CARR_DUTY:    set_duty         = data[CARR_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic write_timing(input logic [CFG_D_W-1:0] hm, hs, bm, one_sp, zero_sp,
                                input logic [CFG_D_W-1:0] per, duty);
        write_reg(REG_HEADER_MARK, hm);
        write_reg(REG_HEADER_SPACE, hs);
        write_reg(REG_BIT_MARK, bm);
        write_reg(REG_ONE_SPACE, one_sp);
        write_reg(REG_ZERO_SPACE, zero_sp);
        write_reg(REG_CARR_PERIOD, per);
        write_reg(REG_CARR_DUTY, duty);
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_SPARE, CFG_D_W'($urandom_range(0, 20'hFFFFF)));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_ticks(input int unsigned n);
        repeat (n) pending_words.push_back(make_word(KIND_TICK));
    endtask

    task automatic push_start(input logic [7:0] a, input logic [7:0] c);
        in_word_t w;
        w.kind          = KIND_START;
        w.frame_address = a;
        w.frame_command = c;
        pending_words.push_back(w);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || expected_status.size() != 0 || in_valid);
        repeat (3) @(negedge clk);
    endtask

    task automatic finish_frame();
        wait_drained();
        while (tx_phase != PH_IDLE)
        begin
            push_ticks(8);
            wait_drained();
        end
    endtask

    // Mostly whole frames with random bytes and the odd start while busy, plus noise
    task automatic push_random_words(input int unsigned count);
        int unsigned sent;
        int unsigned span;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                pending_words.push_back(make_word(KIND_START));
                span = ticks_of(set_header_mark) + ticks_of(set_header_space)
                       + 33 * ticks_of(set_bit_mark)
                       + 32 * ticks_of((set_one_space > set_zero_space) ? set_one_space
                                                                        : set_zero_space)
                       + $urandom_range(0, 4);
                repeat (span)
                begin
                    if ($urandom_range(0, 99) < 4)
                        pending_words.push_back(make_word(KIND_START));
                    pending_words.push_back(make_word(KIND_TICK));
                end
                sent += span + 1;
            end
            else
            begin
                span = $urandom_range(1, 8);
                repeat (span) pending_words.push_back(make_word(1'($urandom_range(0, 1))));
                sent += span;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [15:0] per;
        logic [15:0] dty;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset timings: idle tick, start, start while busy, header mark with reset carrier
        push_ticks(1);
        push_start(8'hFF, 8'h00);
        push_start(8'h00, 8'hFF);
        push_ticks(20);
        wait_drained();
        // shorten every interval mid-frame; zero-length header mark ends on the next tick
        write_timing(20'd0, 20'd1, 20'd2, 20'd3, 20'd0, 20'hF0004, 20'h00002);
        push_ticks(4);
        push_start(8'h12, 8'h34);
        finish_frame();

        // widest values, then drop the period and header mark below what has elapsed
        write_timing(DUR_MAX, 20'd0, 20'd1, 20'd1, 20'd2, DUR_MAX, DUR_MAX);
        push_start(8'hA5, 8'h3C);
        push_ticks(40);
        wait_drained();
        write_timing(20'd3, 20'd0, 20'd0, 20'd1, 20'd0, 20'd2, 20'd1);
        push_ticks(10);
        finish_frame();

        for (int s = 0; s < 8; s++)
        begin
            case (s)
                0: write_timing('0, '0, '0, '0, '0, '0, '0);
                1: write_timing(20'd3, 20'd3, 20'd3, 20'd3, 20'd3, 20'hF0000, DUR_MAX);
                default:
                begin
                    case ($urandom_range(0, 4))
                        0, 1:    per = 16'($urandom_range(0, 3));
                        2, 3:    per = 16'($urandom_range(4, 30));
                        default: per = 16'($urandom_range(0, 65535));
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        dty = 16'($urandom_range(0, 65535));
                    else
                        dty = 16'($urandom_range(0, per + 2));
                    write_timing(CFG_D_W'($urandom_range(0, 3)), CFG_D_W'($urandom_range(0, 3)),
                                 CFG_D_W'($urandom_range(0, 3)), CFG_D_W'($urandom_range(0, 3)),
                                 CFG_D_W'($urandom_range(0, 3)),
                                 {4'($urandom_range(0, 15)), per},
                                 {4'($urandom_range(0, 15)), dty});
                end
            endcase
            push_random_words(110);
            finish_frame();
        end

        wait_drained();
        repeat (5) @(negedge clk);
        if (error_count == 0)
            $display("tb_nec_ir_frame_transmitter_unit: clean");
        else
            $display("tb_nec_ir_frame_transmitter_unit: errors");
        $finish;
    end

    initial
    begin : watchdog
        #50_000_000;
        $display("tb_nec_ir_frame_transmitter_unit: errors");
        $finish;
    end

endmodule

[filelist.f]
rtl/necirtx_pkg.sv
rtl/nec_ir_frame_transmitter_unit.sv
sim/tb_nec_ir_frame_transmitter_unit.sv
